/* rtl/acv_pkg.sv */
// ----------------------------------------------------------------------------
// acv_pkg
// Shared types, curve codes and fixed-point constants of the automation
// curve interpolator.
// ----------------------------------------------------------------------------
package acv_pkg;

   // curve codes
   localparam logic [2:0] CURVE_LINEAR = 3'd0;
   localparam logic [2:0] CURVE_SQUARE = 3'd1;
   localparam logic [2:0] CURVE_SQRT   = 3'd2;
   localparam logic [2:0] CURVE_SCURVE = 3'd3;
   localparam logic [2:0] CURVE_STEP   = 3'd4;

   localparam int LEVEL_BITS = 7;
   localparam int KIND_BITS  = 3;

   // Q1.30 arithmetic of the S-curve
   localparam int          Q30_W      = 31;
   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [30:0] Q30_HALF   = 31'h2000_0000;
   localparam logic [30:0] PI_HALF    = 31'd1686629713;
   localparam int          RECIP_SHIFT = 36;
   localparam logic [33:0] RECIP_42 = 34'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42);
   localparam logic [33:0] RECIP_20 = 34'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
   localparam logic [33:0] RECIP_6  = 34'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);

   // S-curve sequence, one step per pipeline stage
   localparam int SC_FOLD  = 0;
   localparam int SC_ANGLE = 1;
   localparam int SC_ASQ   = 2;
   localparam int SC_T1    = 3;
   localparam int SC_M1    = 4;
   localparam int SC_T2    = 5;
   localparam int SC_M2    = 6;
   localparam int SC_T3    = 7;
   localparam int SC_SIN   = 8;
   localparam int SC_SQR   = 9;
   localparam int SC_OUT   = 10;
   localparam int SC_STEPS = 11;

   // sideband that travels with every word
   typedef struct packed {
      logic                  valid;
      logic                  bypass;
      logic [LEVEL_BITS-1:0] byp_level;
      logic [LEVEL_BITS-1:0] start_level;
      logic [LEVEL_BITS-1:0] end_level;
      logic [KIND_BITS-1:0]  kind;
   } side_type;

   // floor(a * b / 2^30)
   function automatic logic [30:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] prod;
      prod = {31'd0, a} * {31'd0, b};
      return prod[60:30];
   endfunction

   // floor(x / d) through the reciprocal m = ceil(2^36 / d), exact for x < 2^31
   function automatic logic [30:0] recip_div(input logic [30:0] x, input logic [33:0] m);
      logic [64:0] prod;
      prod = {34'd0, x} * {31'd0, m};
      return prod[RECIP_SHIFT+30:RECIP_SHIFT];
   endfunction

endpackage

/* rtl/acv_req_if.sv */
// ----------------------------------------------------------------------------
// acv_req_if
// Query channel: segment breakpoints, query time and curve code.
// ----------------------------------------------------------------------------
interface acv_req_if #(
   parameter int TIME_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           curve_kind;
   logic [TIME_BITS-1:0] seg_start_time;
   logic [TIME_BITS-1:0] seg_end_time;
   logic [TIME_BITS-1:0] query_time;
   logic [6:0]           seg_start_level;
   logic [6:0]           seg_end_level;

   modport source (output valid, curve_kind, seg_start_time, seg_end_time, query_time,
                   seg_start_level, seg_end_level, input ready);
   modport sink (input valid, curve_kind, seg_start_time, seg_end_time, query_time,
                 seg_start_level, seg_end_level, output ready);
endinterface

/* rtl/acv_rsp_if.sv */
// ----------------------------------------------------------------------------
// acv_rsp_if
// Result channel: interpolated controller level.
// ----------------------------------------------------------------------------
interface acv_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] level_out;

   modport source (output valid, level_out, input ready);
   modport sink (input valid, level_out, output ready);
endinterface

/* rtl/automation_curve_interpolator.sv */
// ----------------------------------------------------------------------------
// automation_curve_interpolator
// Level of one automation segment at a query time, shaped by a curve.
// ----------------------------------------------------------------------------
// Fully pipelined: one query enters per clock while the result side does not
// stall. A query passes the capture register, then the restoring divider,
// one quotient bit per stage, then the curve stages, where the square root
// takes one result bit per stage and the S-curve one step per stage, and last
// the output register. A stall on the result side freezes the whole pipe;
// nothing is dropped or repeated.
module automation_curve_interpolator #(
   parameter int TIME_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input logic  clock,
   input logic  reset,
   acv_req_if.sink   req_ch,
   acv_rsp_if.source rsp_ch
);
   import acv_pkg::*;

   localparam int TW   = TIME_BITS;
   localparam int FW   = FRAC_BITS;
   localparam int CL   = (FW > SC_STEPS) ? FW : SC_STEPS;
   localparam int LAST = FW + CL;
   localparam int SH   = 30 - FW;

   logic adv;

   logic [TW-1:0]         dv_rem_ff [0:FW];
   logic [TW-1:0]         dv_den_ff [0:FW];
   logic [FW-1:0]         dv_q_ff   [0:FW];
   side_type              sd_ff     [0:LAST];

   logic [FW-1:0]   sp_p_ff    [1:CL];
   logic [FW-1:0]   sp_sq_ff   [1:CL];
   logic [FW+1:0]   sr_rem_ff  [1:CL];
   logic [FW-1:0]   sr_root_ff [1:CL];
   logic [2*FW-1:0] sr_x_ff    [1:CL];
   logic [30:0]     sc_x_ff    [1:CL];
   logic [30:0]     sc_a_ff    [1:CL];
   logic [30:0]     sc_a2_ff   [1:CL];
   logic            sc_flag_ff [1:CL];

   logic            rsp_valid_ff;
   logic [6:0]      rsp_level_ff;

   // advance every stage when the output register is empty or being taken
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.level_out = rsp_level_ff;

   // capture: boundary tests and divider operands
   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sd_ff[0].valid <= req_ch.valid;
      end
      if (adv) begin
         sd_ff[0].bypass <= (req_ch.query_time <= req_ch.seg_start_time) ||
                            (req_ch.query_time >= req_ch.seg_end_time);
         sd_ff[0].byp_level <= (req_ch.query_time <= req_ch.seg_start_time) ?
                               req_ch.seg_start_level : req_ch.seg_end_level;
         sd_ff[0].start_level <= req_ch.seg_start_level;
         sd_ff[0].end_level   <= req_ch.seg_end_level;
         sd_ff[0].kind        <= req_ch.curve_kind;
         dv_rem_ff[0] <= req_ch.query_time - req_ch.seg_start_time;
         dv_den_ff[0] <= req_ch.seg_end_time - req_ch.seg_start_time;
         dv_q_ff[0]   <= '0;
      end
   end

   // shift the sideband along with the data
   for (genvar i = 0; i < LAST; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[i+1].valid <= 1'b0;
         end else if (adv) begin
            sd_ff[i+1].valid <= sd_ff[i].valid;
         end
         if (adv) begin
            sd_ff[i+1].bypass      <= sd_ff[i].bypass;
            sd_ff[i+1].byp_level   <= sd_ff[i].byp_level;
            sd_ff[i+1].start_level <= sd_ff[i].start_level;
            sd_ff[i+1].end_level   <= sd_ff[i].end_level;
            sd_ff[i+1].kind        <= sd_ff[i].kind;
         end
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < FW; k++) begin : g_div
      logic [TW:0]   r2;
      logic          take;
      logic [TW-1:0] rem_in;
      logic [FW-1:0] q_in;

      always_comb begin
         r2     = {dv_rem_ff[k], 1'b0};
         take   = (r2 >= {1'b0, dv_den_ff[k]});
         rem_in = take ? TW'(r2 - {1'b0, dv_den_ff[k]}) : r2[TW-1:0];
         q_in   = {dv_q_ff[k][FW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k+1] <= rem_in;
            dv_den_ff[k+1] <= dv_den_ff[k];
            dv_q_ff[k+1]   <= q_in;
         end
      end
   end

   // curve stages: square at the first, root bit per stage, S-curve step per stage
   for (genvar k = 0; k < CL; k++) begin : g_shape
      logic [FW-1:0]   p_s, sq_s, root_s;
      logic [FW+1:0]   rem_s;
      logic [2*FW-1:0] x_s;
      logic [30:0]     cx_s, ca_s, ca2_s;
      logic            cf_s;

      logic [FW-1:0]   sq_in, root_in;
      logic [FW+1:0]   rem_in, r2, trial;
      logic [2*FW-1:0] x_in, pp;
      logic [30:0]     cx_in, ca_in, ca2_in, u;
      logic            cf_in;

      if (k == 0) begin : g_src0
         assign p_s    = dv_q_ff[FW];
         assign sq_s   = '0;
         assign rem_s  = '0;
         assign root_s = '0;
         assign x_s    = {dv_q_ff[FW], FW'(0)};
         assign cx_s   = '0;
         assign ca_s   = '0;
         assign ca2_s  = '0;
         assign cf_s   = 1'b0;
      end else begin : g_srcn
         assign p_s    = sp_p_ff[k];
         assign sq_s   = sp_sq_ff[k];
         assign rem_s  = sr_rem_ff[k];
         assign root_s = sr_root_ff[k];
         assign x_s    = sr_x_ff[k];
         assign cx_s   = sc_x_ff[k];
         assign ca_s   = sc_a_ff[k];
         assign ca2_s  = sc_a2_ff[k];
         assign cf_s   = sc_flag_ff[k];
      end

      // square weight
      always_comb begin
         pp    = {FW'(0), p_s} * {FW'(0), p_s};
         sq_in = (k == 0) ? pp[2*FW-1:FW] : sq_s;
      end

      // square root: bring down two bits, try the next root bit
      always_comb begin
         r2    = {rem_s[FW-1:0], x_s[2*FW-1:2*FW-2]};
         trial = {root_s, 2'b01};
         if (k < FW) begin
            x_in = {x_s[2*FW-3:0], 2'b00};
            if (r2 >= trial) begin
               rem_in  = r2 - trial;
               root_in = {root_s[FW-2:0], 1'b1};
            end else begin
               rem_in  = r2;
               root_in = {root_s[FW-2:0], 1'b0};
            end
         end else begin
            x_in    = x_s;
            rem_in  = rem_s;
            root_in = root_s;
         end
      end

      // S-curve step
      always_comb begin
         u      = {1'b0, p_s, SH'(0)};
         cx_in  = cx_s;
         ca_in  = ca_s;
         ca2_in = ca2_s;
         cf_in  = cf_s;
         case (k)
            SC_FOLD: begin
               cf_in = (u > Q30_HALF);
               cx_in = (u > Q30_HALF) ? (Q30_ONE - u) : u;
            end
            SC_ANGLE: ca_in  = q30_mul(cx_s, PI_HALF);
            SC_ASQ:   ca2_in = q30_mul(ca_s, ca_s);
            SC_T1:    cx_in  = Q30_ONE - recip_div(ca2_s, RECIP_42);
            SC_M1:    cx_in  = q30_mul(ca2_s, cx_s);
            SC_T2:    cx_in  = Q30_ONE - recip_div(cx_s, RECIP_20);
            SC_M2:    cx_in  = q30_mul(ca2_s, cx_s);
            SC_T3:    cx_in  = Q30_ONE - recip_div(cx_s, RECIP_6);
            SC_SIN:   cx_in  = q30_mul(ca_s, cx_s);
            SC_SQR:   cx_in  = q30_mul(cx_s, cx_s);
            SC_OUT:   cx_in  = (cf_s ? (Q30_ONE - cx_s) : cx_s) >> SH;
            default:  cx_in  = cx_s;
         endcase
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sp_p_ff[k+1]    <= p_s;
            sp_sq_ff[k+1]   <= sq_in;
            sr_rem_ff[k+1]  <= rem_in;
            sr_root_ff[k+1] <= root_in;
            sr_x_ff[k+1]    <= x_in;
            sc_x_ff[k+1]    <= cx_in;
            sc_a_ff[k+1]    <= ca_in;
            sc_a2_ff[k+1]   <= ca2_in;
            sc_flag_ff[k+1] <= cf_in;
         end
      end
   end

   // pick the weight and blend the levels
   logic [FW:0]   w_sel;
   logic [6:0]    diff;
   logic [FW+7:0] prod, base, sum;
   logic [6:0]    level_in;
   side_type      sd_last;

   assign sd_last = sd_ff[LAST];

   always_comb begin
      case (sd_last.kind)
         CURVE_SQUARE: w_sel = {1'b0, sp_sq_ff[CL]};
         CURVE_SQRT:   w_sel = {1'b0, sr_root_ff[CL]};
         CURVE_SCURVE: w_sel = sc_x_ff[CL][FW:0];
         CURVE_STEP:   w_sel = '0;
         default:      w_sel = {1'b0, sp_p_ff[CL]};
      endcase
      diff = (sd_last.end_level >= sd_last.start_level) ?
             (sd_last.end_level - sd_last.start_level) :
             (sd_last.start_level - sd_last.end_level);
      prod = (FW+8)'(diff) * (FW+8)'(w_sel);
      base = {1'b0, sd_last.start_level, FW'(0)};
      sum  = (sd_last.end_level >= sd_last.start_level) ? (base + prod) : (base - prod);
      level_in = sd_last.bypass ? sd_last.byp_level : sum[FW+6:FW];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sd_last.valid;
      end
      if (adv) begin
         rsp_level_ff <= level_in;
      end
   end

`ifndef NO_ASSERTIONS
   // hold the input while a result waits
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while the output is stalled");

   // weight never exceeds one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (sd_last.valid && !sd_last.bypass) |-> (w_sel <= {1'b1, FW'(0)}))
      else $error("curve weight above one");

   // result valid follows the last stage when the pipe moves
   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      adv |=> (rsp_valid_ff == $past(sd_last.valid)))
      else $error("result valid lost or invented");

   // a frozen pipe keeps its last stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(sd_last.valid) && $stable(w_sel)))
      else $error("pipeline moved during a stall");
`endif

endmodule
